FILE: rtl/sact_pkg.sv
// Package with shared constants, codes and a helper function for the tag lookup core.
`timescale 1ns / 1ps
`default_nettype none
package sact_pkg;
    localparam int unsigned DEF_MAX_SETS = 1024;
    localparam int unsigned DEF_MAX_WAYS = 8;
    localparam logic [15:0] LFSR_SEED = 16'hACE1;
    localparam logic [15:0] LFSR_MASK = 16'hB400;

    localparam logic [1:0] REG_SET_LOG2   = 2'd0;
    localparam logic [1:0] REG_BLOCK_LOG2 = 2'd1;
    localparam logic [1:0] REG_WAYS       = 2'd2;
    localparam logic [1:0] REG_POLICY     = 2'd3;

    localparam logic [1:0] POL_RANDOM   = 2'd0;
    localparam logic [1:0] POL_FIFO     = 2'd1;
    localparam logic [1:0] POL_LRU      = 2'd2;
    // The spare policy code behaves as LRU.
    localparam logic [1:0] POL_RESERVED = 2'd3;

    localparam logic [1:0] KIND_HIT        = 2'd0;
    localparam logic [1:0] KIND_COMPULSORY = 2'd1;
    localparam logic [1:0] KIND_CAPACITY   = 2'd2;
    localparam logic [1:0] KIND_CONFLICT   = 2'd3;

    function automatic logic [15:0] lfsr_step(input logic [15:0] l);
        lfsr_step = l[0] ? ((l >> 1) ^ LFSR_MASK) : (l >> 1);
    endfunction
endpackage
`default_nettype wire

FILE: rtl/sact_ram.sv
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
`default_nettype none
module sact_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

FILE: rtl/sact_victim.sv
// Way selection: hit search, first empty way, and replacement victim choice.
`timescale 1ns / 1ps
`default_nettype none
module sact_victim #(
    parameter int unsigned MAX_WAYS = sact_pkg::DEF_MAX_WAYS,
    parameter int unsigned WW = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1
) (
    input  wire logic [MAX_WAYS-1:0]       i_valid,
    input  wire logic [MAX_WAYS-1:0][31:0] i_tags,
    input  wire logic [MAX_WAYS-1:0][31:0] i_ages,
    input  wire logic [31:0]               i_tag,
    input  wire logic [MAX_WAYS-1:0]       i_in_use,
    input  wire logic                      i_random,
    input  wire logic [WW-1:0]             i_rand_way,
    output logic                           o_hit,
    output logic                           o_empty,
    output logic [WW-1:0]                  o_way
);
    logic [WW-1:0] hit_way, empty_way, old_way;
    logic [31:0]   old_age;

    // The way count is small, so a priority scan over ways is fine here.
    always_comb begin
        o_hit     = 1'b0;
        o_empty   = 1'b0;
        hit_way   = '0;
        empty_way = '0;
        old_way   = '0;
        old_age   = i_ages[0];
        for (int i = MAX_WAYS - 1; i >= 0; i--) begin
            if (i_in_use[i] && i_valid[i] && i_tags[i] == i_tag) begin
                o_hit   = 1'b1;
                hit_way = WW'(i);
            end
            if (i_in_use[i] && !i_valid[i]) begin
                o_empty   = 1'b1;
                empty_way = WW'(i);
            end
        end
        for (int i = 1; i < MAX_WAYS; i++) begin
            if (i_in_use[i] && i_ages[i] < old_age) begin
                old_age = i_ages[i];
                old_way = WW'(i);
            end
        end
        if (o_hit) begin
            o_way = hit_way;
        end else if (o_empty) begin
            o_way = empty_way;
        end else if (i_random) begin
            o_way = i_rand_way;
        end else begin
            o_way = old_way;
        end
    end
endmodule
`default_nettype wire

FILE: rtl/set_assoc_cache_tag_lookup_core.sv
// Top level of the set-associative cache tag lookup core.
`timescale 1ns / 1ps
`default_nettype none
// Each address beat is looked up in a set-associative tag store held in
// per-way synchronous RAMs (tag and age, one row per set) plus one RAM of
// valid bits with one row per set. From acceptance to result an item is
// read (the set's row from every way in parallel), compared to choose the
// way, and written back (tag and valid bits on a miss, stamp on a miss or
// a non-random, non-FIFO hit) while the result register is loaded. The
// next address is taken in the cycle after the write-back, so the
// read-modify-write of the set row ends before a new item is taken. A
// result that waits for the receiver does not block the input: the next
// item runs up to its write-back step and holds there until the result
// register is free. The random victim is an LFSR modulo the ways in use,
// reduced by a small shift-subtract unit only on random replacement misses.
// After reset a clearing pass zeroes the valid RAM and stalls the input
// until it ends. The user must write configuration only while idle; the
// core itself does not enforce this.
module set_assoc_cache_tag_lookup_core #(
    parameter int unsigned MAX_SETS = sact_pkg::DEF_MAX_SETS,
    parameter int unsigned MAX_WAYS = sact_pkg::DEF_MAX_WAYS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [3:0]  i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [31:0] i_address,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_hit,
    output logic [1:0]       o_miss_kind,
    output logic [2:0]       o_way_used,
    output logic [31:0]      o_access_count,
    output logic [31:0]      o_hit_count,
    output logic [31:0]      o_miss_count,
    output logic [31:0]      o_compulsory_count,
    output logic [31:0]      o_capacity_count,
    output logic [31:0]      o_conflict_count
);
    import sact_pkg::*;

    localparam int unsigned SW = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int unsigned WW = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int unsigned SMAX = $clog2(MAX_SETS + 1) - 1;  // largest usable set_log2
    localparam int unsigned CW = $clog2(MAX_WAYS + 1);

    typedef enum logic [2:0] {
        ST_IDLE, ST_READ, ST_PICK, ST_MOD, ST_WRITE, ST_CLEAR
    } t_state;

    // Configuration registers; every index of the two-bit field is defined.
    logic [3:0] r_set_log2, r_block_log2, r_ways;
    logic [1:0] r_policy;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_log2   <= 4'd0;
            r_block_log2 <= 4'd2;
            r_ways       <= 4'd1;
            r_policy     <= POL_LRU;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_SET_LOG2:   r_set_log2   <= i_cfg_data;
                REG_BLOCK_LOG2: r_block_log2 <= i_cfg_data;
                REG_WAYS:       r_ways       <= i_cfg_data;
                REG_POLICY:     r_policy     <= i_cfg_data[1:0];
                default:        r_ways       <= r_ways;
            endcase
        end
    end

    // Effective geometry.
    logic [4:0]    slog;
    logic [CW-1:0] ways;
    always_comb begin
        slog = (32'(r_set_log2) > SMAX) ? 5'(SMAX) : {1'b0, r_set_log2};
        if (r_ways == 4'd0) begin
            ways = CW'(1);
        end else if (32'(r_ways) > MAX_WAYS) begin
            ways = CW'(MAX_WAYS);
        end else begin
            ways = CW'(r_ways);
        end
    end

    t_state r_state;
    logic [31:0] r_tag;
    logic [SW-1:0] r_set;
    logic [SW-1:0] r_clr;
    logic [MAX_WAYS-1:0] rd_vld, r_row_vld, vld_wdata;
    logic [SW-1:0] vld_waddr;
    logic vld_we;
    logic [MAX_WAYS-1:0][31:0] rd_tag, rd_age;
    logic [WW-1:0] r_way;
    logic r_hit_i, r_empty;
    logic [15:0] r_lfsr, r_rem;
    logic [4:0]  r_div_cnt;
    logic [31:0] r_acc, r_hitc, r_missc, r_compc, r_capc, r_confc;
    logic we;
    logic wr_go;

    logic [31:0] block;
    assign block = i_address >> r_block_log2;

    logic [MAX_WAYS-1:0] in_use;
    always_comb begin
        for (int i = 0; i < MAX_WAYS; i++) begin
            in_use[i] = (32'(i) < 32'(ways));
        end
    end

    logic sel_hit, sel_empty;
    logic [WW-1:0] sel_way;
    logic is_random;
    assign is_random = (r_policy == POL_RANDOM);

    sact_victim #(.MAX_WAYS(MAX_WAYS), .WW(WW)) u_victim (
        .i_valid   (rd_vld),
        .i_tags    (rd_tag),
        .i_ages    (rd_age),
        .i_tag     (r_tag),
        .i_in_use  (in_use),
        .i_random  (is_random),
        .i_rand_way(r_rem[WW-1:0]),
        .o_hit     (sel_hit),
        .o_empty   (sel_empty),
        .o_way     (sel_way)
    );

    logic [31:0] acc_next;
    assign acc_next = r_acc + 32'd1;

    // The write-back step fires only once the result register can take a beat.
    assign wr_go = (r_state == ST_WRITE) && !(o_valid && i_stall);
    assign we = wr_go &&
                (!r_hit_i || (r_policy != POL_RANDOM && r_policy != POL_FIFO));

    genvar g;
    for (g = 0; g < MAX_WAYS; g++) begin : g_way
        logic wsel;
        assign wsel = we && (r_way == WW'(g));
        sact_ram #(.WIDTH(32), .DEPTH(MAX_SETS)) u_tag (
            .i_clk(i_clk), .i_we(wsel && !r_hit_i), .i_waddr(r_set), .i_wdata(r_tag),
            .i_raddr(r_set), .o_rdata(rd_tag[g])
        );
        sact_ram #(.WIDTH(32), .DEPTH(MAX_SETS)) u_age (
            .i_clk(i_clk), .i_we(wsel), .i_waddr(r_set), .i_wdata(r_acc),
            .i_raddr(r_set), .o_rdata(rd_age[g])
        );
    end

    // Valid bits of a set live in one row; the clearing pass zeroes every row.
    assign vld_we    = (r_state == ST_CLEAR) || (wr_go && !r_hit_i);
    assign vld_waddr = (r_state == ST_CLEAR) ? r_clr : r_set;
    assign vld_wdata = (r_state == ST_CLEAR) ? '0 :
                       (r_row_vld | (MAX_WAYS'(1) << r_way));

    sact_ram #(.WIDTH(MAX_WAYS), .DEPTH(MAX_SETS)) u_vld (
        .i_clk(i_clk), .i_we(vld_we), .i_waddr(vld_waddr), .i_wdata(vld_wdata),
        .i_raddr(r_set), .o_rdata(rd_vld)
    );

    assign o_stall = (r_state != ST_IDLE);

    logic [15:0] n_lfsr;
    assign n_lfsr = lfsr_step(r_lfsr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
            o_valid <= 1'b0;
            r_lfsr  <= LFSR_SEED;
            r_acc   <= '0;
            r_hitc  <= '0;
            r_missc <= '0;
            r_compc <= '0;
            r_capc  <= '0;
            r_confc <= '0;
        end else begin
            if (wr_go) begin
                o_valid <= 1'b1;
            end else if (!i_stall) begin
                o_valid <= 1'b0;
            end
            case (r_state)
                ST_CLEAR: begin
                    r_clr <= r_clr + SW'(1);
                    if (r_clr == SW'(MAX_SETS - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (i_valid && !o_stall) begin
                        r_set   <= SW'(block & ((32'd1 << slog) - 32'd1));
                        r_tag   <= block >> slog;
                        r_state <= ST_READ;
                    end
                end
                ST_READ: begin
                    // RAM read issued with r_set; data arrives next cycle.
                    r_acc     <= acc_next;
                    r_state   <= ST_PICK;
                end
                ST_PICK: begin
                    r_row_vld <= rd_vld;
                    r_hit_i   <= sel_hit;
                    r_empty   <= sel_empty;
                    r_way     <= sel_way;
                    if (!sel_hit && !sel_empty && is_random) begin
                        r_lfsr    <= n_lfsr;
                        r_rem     <= n_lfsr;
                        r_div_cnt <= 5'd16;
                        r_state   <= ST_MOD;
                    end else begin
                        r_state <= ST_WRITE;
                    end
                end
                ST_MOD: begin
                    // Restoring reduction: subtract ways << k for k = 15..0.
                    if (r_div_cnt == 5'd0) begin
                        r_way   <= r_rem[WW-1:0];
                        r_state <= ST_WRITE;
                    end else begin
                        if ({16'd0, r_rem} >= (32'(ways) << (r_div_cnt - 5'd1))) begin
                            r_rem <= 16'({16'd0, r_rem} - (32'(ways) << (r_div_cnt - 5'd1)));
                        end
                        r_div_cnt <= r_div_cnt - 5'd1;
                    end
                end
                ST_WRITE: begin
                    if (wr_go) begin
                        o_hit          <= r_hit_i;
                        o_way_used     <= 3'(r_way);
                        o_access_count <= r_acc;
                        if (r_hit_i) begin
                            r_hitc      <= r_hitc + 32'd1;
                            o_hit_count <= r_hitc + 32'd1;
                            o_miss_kind <= KIND_HIT;
                        end else begin
                            r_missc     <= r_missc + 32'd1;
                            o_hit_count <= r_hitc;
                            if (r_empty) begin
                                r_compc     <= r_compc + 32'd1;
                                o_miss_kind <= KIND_COMPULSORY;
                            end else if (ways == CW'(1)) begin
                                r_confc     <= r_confc + 32'd1;
                                o_miss_kind <= KIND_CONFLICT;
                            end else begin
                                r_capc      <= r_capc + 32'd1;
                                o_miss_kind <= KIND_CAPACITY;
                            end
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Miss counters are shown straight from their registers as they settle.
    assign o_miss_count       = r_missc;
    assign o_compulsory_count = r_compc;
    assign o_capacity_count   = r_capc;
    assign o_conflict_count   = r_confc;
endmodule
`default_nettype wire
